/* design/bitmap_block_allocator_top_assert.svh */
// Assertion macros shared by the allocator checker.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, dropped while rst is high.
`define BBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on clk, dropped while rst is high.
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

/* design/bba_pkg.sv */
// Types, constants and helpers shared by the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int NUM_BLOCKS    = 64;
  localparam int MAP_W         = NUM_BLOCKS;
  localparam int IDX_W         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 17;
  localparam int BLOCK_INDEX_W = 6;
  localparam int STATUS_W      = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int PROD_W        = IDX_W + SIZE_W;
  localparam int DIV_CNT_W     = $clog2(ADDR_W + 1);
  localparam int GUARD_BYTES   = 4;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = SIZE_W'(16);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_FULL        = 2'd1,
    STATUS_ZERO_SIZE   = 2'd2,
    STATUS_BAD_ADDRESS = 2'd3
  } status_t;

  typedef enum logic {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_BLOCK_SIZE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_ALLOC_ADDR,
    S_FREE_WAIT
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [ADDR_W-1:0]        user_address;
    logic [BLOCK_INDEX_W-1:0] block_index;
  } res_t;

  // Mask of all map positions whose index has bit b set; drives the encoder.
  function automatic logic [MAP_W-1:0] index_bit_mask(input int unsigned b);
    logic [MAP_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < MAP_W; i++) begin
      m[i] = ((i >> b) & 1) != 0;
    end
    return m;
  endfunction

endpackage

/* design/bba_divider.sv */
// Radix-2 restoring divider: 32-bit dividend by 17-bit divisor, one bit a cycle.
`timescale 1ns / 1ps

module bba_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bba_pkg::ADDR_W-1:0] dividend,
  input  logic [bba_pkg::SIZE_W-1:0] divisor,
  output logic                       done,
  output logic [bba_pkg::ADDR_W-1:0] quotient,
  output logic [bba_pkg::SIZE_W-1:0] remainder
);
  import bba_pkg::*;

  logic                 active;
  logic [DIV_CNT_W-1:0] count;
  logic [SIZE_W-1:0]    divisor_r;
  logic [SIZE_W:0]      partial;
  logic [SIZE_W:0]      trial;

  // Shift in the next dividend bit and try one subtract.
  assign partial = {remainder, quotient[ADDR_W-1]};
  assign trial   = partial - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= DIV_CNT_W'(ADDR_W);
      end else if (active) begin
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      divisor_r <= divisor;
    end else if (active) begin
      // Restore on a negative trial, keep the difference otherwise.
      remainder <= trial[SIZE_W] ? partial[SIZE_W-1:0] : trial[SIZE_W-1:0];
      quotient  <= {quotient[ADDR_W-2:0], ~trial[SIZE_W]};
    end
  end

endmodule

/* design/bitmap_block_allocator_top.sv */
// Top level of the bitmap fixed-size block allocator.
`timescale 1ns / 1ps

// Bitmap block allocator. The block hands out 64 equal blocks laid out from
// base_address at a stride of block_size bytes and tracks them in a free map
// (reset marks all free). A command beat is taken at a clock edge with start
// high and busy low; busy then stays high until the result is ready. An
// allocate claims the lowest free block and returns
// base_address + index * block_size + 4 (the 4 bytes skip a front guard),
// all modulo 2^32; a zero request_size returns the zero-size status and a
// full map returns the full status. A free subtracts the guard and the base,
// divides by block_size and frees that block; a misaligned, out-of-range or
// already-free address returns the bad-address status and changes nothing.
// Every command yields exactly one result beat, shown on result for one cycle
// with result_valid high; the receiver cannot stall, so capture it then.
// Sequencing: an allocate that finds a block passes through S_ALLOC (search),
// then S_ALLOC_ADDR (the index multiply and address add); zero-size and full
// allocates finish in S_ALLOC. A free waits in S_FREE_WAIT on the
// one-bit-per-cycle divider, which runs 32 steps. Configuration writes go
// through cfg_valid/cfg_ready (always ready) and must be made while idle.
module bitmap_block_allocator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bba_pkg::req_t                  request,
  output logic                           result_valid,
  output bba_pkg::res_t                  result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  bba_pkg::cfg_reg_t              cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bba_pkg::*;

  // Configuration registers.
  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] block_size;

  // Control state.
  state_t           state, state_next;
  logic [MAP_W-1:0] free_map, free_map_next;
  logic             result_valid_next;

  // Payload holding registers.
  logic [SIZE_W-1:0] req_size, req_size_next;
  logic [IDX_W-1:0]  alloc_idx, alloc_idx_next;
  res_t              result_next;

  // Allocate search: isolate the lowest free bit and encode it.
  logic [MAP_W-1:0]  lowest_free;
  logic [IDX_W-1:0]  found_idx;
  logic [PROD_W-1:0] block_offset;
  logic [ADDR_W-1:0] alloc_address;

  // Free path through the divider.
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] free_offset;
  logic [ADDR_W-1:0] div_quotient;
  logic [SIZE_W-1:0] div_remainder;
  logic [IDX_W-1:0]  free_idx;
  logic              free_bad;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Register beats land whenever valid; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_size   <= BLOCK_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        CFG_BLOCK_SIZE:   block_size   <= cfg_data[SIZE_W-1:0];
        default:          ;
      endcase
    end
  end

  assign lowest_free = free_map & (~free_map + MAP_W'(1));

  always_comb begin
    for (int unsigned b = 0; b < IDX_W; b++) begin
      found_idx[b] = |(lowest_free & index_bit_mask(b));
    end
  end

  // Multiply the held index by the stride, then add base and guard.
  assign block_offset  = PROD_W'(alloc_idx) * PROD_W'(block_size);
  assign alloc_address = base_address + ADDR_W'(block_offset) + ADDR_W'(GUARD_BYTES);

  // Undo the guard and base at accept; the divider latches this offset.
  assign free_offset = request.free_address - ADDR_W'(GUARD_BYTES) - base_address;

  bba_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (free_offset),
    .divisor   (block_size),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Reject misaligned, out-of-range and already-free blocks, and a zero stride.
  assign free_idx = div_quotient[IDX_W-1:0];
  assign free_bad = (block_size == '0) || (div_remainder != '0) ||
                    (div_quotient >= ADDR_W'(NUM_BLOCKS)) || free_map[free_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_map     <= '1;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      free_map     <= free_map_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_size  <= req_size_next;
    alloc_idx <= alloc_idx_next;
    result    <= result_next;
  end

  always_comb begin
    state_next        = state;
    free_map_next     = free_map;
    result_valid_next = 1'b0;
    req_size_next     = req_size;
    alloc_idx_next    = alloc_idx;
    result_next       = result;
    div_start         = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          req_size_next = request.request_size;
          if (request.cmd == CMD_ALLOC) begin
            state_next = S_ALLOC;
          end else begin
            div_start  = 1'b1;
            state_next = S_FREE_WAIT;
          end
        end
      end
      S_ALLOC: begin
        if (req_size == '0) begin
          result_next.status       = STATUS_ZERO_SIZE;
          result_next.user_address = '0;
          result_next.block_index  = '0;
          result_valid_next        = 1'b1;
          state_next               = S_IDLE;
        end else if (free_map == '0) begin
          result_next.status       = STATUS_FULL;
          result_next.user_address = '0;
          result_next.block_index  = '0;
          result_valid_next        = 1'b1;
          state_next               = S_IDLE;
        end else begin
          // Claim the block now; the address follows next cycle.
          alloc_idx_next = found_idx;
          free_map_next  = free_map & ~lowest_free;
          state_next     = S_ALLOC_ADDR;
        end
      end
      S_ALLOC_ADDR: begin
        result_next.status       = STATUS_OK;
        result_next.user_address = alloc_address;
        result_next.block_index  = BLOCK_INDEX_W'(alloc_idx);
        result_valid_next        = 1'b1;
        state_next               = S_IDLE;
      end
      S_FREE_WAIT: begin
        if (div_done) begin
          result_next.user_address = '0;
          if (free_bad) begin
            result_next.status      = STATUS_BAD_ADDRESS;
            result_next.block_index = '0;
          end else begin
            result_next.status      = STATUS_OK;
            result_next.block_index = BLOCK_INDEX_W'(free_idx);
            free_map_next           = free_map | (MAP_W'(1) << free_idx);
          end
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/bba_checker.sv */
// Port-level checker for the block allocator, bound to the top level.
`timescale 1ns / 1ps

module bba_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          result_valid,
  input bba_pkg::res_t result
);
  import bba_pkg::*;
  `include "bitmap_block_allocator_top_assert.svh"

  // An accepted command always makes the block busy in the next cycle.
  `BBA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)

  // The result beat shows only once the block has gone idle.
  `BBA_ASSERT_NOW(a_result_when_idle, result_valid, !busy)

  // Finishing a command always produces its result beat.
  `BBA_ASSERT_NOW(a_done_has_result, $fell(busy), result_valid)

  // A failed command reports zero address and zero index.
  `BBA_ASSERT_NOW(a_fail_zero_fields, result_valid && result.status != STATUS_OK,
                  result.user_address == '0 && result.block_index == '0)

endmodule

bind bitmap_block_allocator_top bba_checker u_checker (.*);
